// ----- sv/assert_macros.svh -----
// Assertion macros shared by the LCD timing RTL.
// Unless SYNTH is defined, each macro expands to a concurrent assertion clocked by clk_i and reset by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Plain property, checked at every rising clock edge outside reset
`define LCDSTAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lcd timing check failed");
// Same-cycle implication
`define LCDSTAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcd timing implication failed");
`else
`define LCDSTAT_ASSERT(lbl, prop)
`define LCDSTAT_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- sv/lcdstat_pkg.sv -----
// Package for the LCD line timing / STAT interrupt block.
// Holds mode codes, dot and line timing constants and bit positions; no dependencies.
`default_nettype none

package lcdstat_pkg;

  // Internal mode codes; the low two bits are what STAT shows
  typedef enum logic [2:0] {
    MODE_HBLANK = 3'd0,
    MODE_VBLANK = 3'd1,
    MODE_OAM    = 3'd2,
    MODE_DRAW   = 3'd3,
    MODE_FIRST  = 3'd4
  } mode_e;

  localparam int unsigned DotW  = 9;
  localparam int unsigned LineW = 8;

  // Dot timing within a line
  localparam logic [DotW-1:0] DOT_SNAP       = 9'd4;
  localparam logic [DotW-1:0] DOT_OAM_LATE   = 9'd76;
  localparam logic [DotW-1:0] DOT_OAM_END    = 9'd80;
  localparam logic [DotW-1:0] DOT_LINE_STEP  = 9'd452;
  localparam logic [DotW-1:0] DOT_LINE_END   = 9'd456;

  // Line timing within a frame
  localparam logic [LineW-1:0] LINE_VBLANK   = 8'd144;
  localparam logic [LineW-1:0] LINE_LAST     = 8'd153;

  // Access-block flag bits
  localparam int unsigned BLK_OAM_R  = 0;
  localparam int unsigned BLK_OAM_W  = 1;
  localparam int unsigned BLK_VRAM_R = 2;
  localparam int unsigned BLK_VRAM_W = 3;

  localparam logic [3:0] BLK_NONE   = 4'b0000;
  localparam logic [3:0] BLK_OAM    = 4'b0011;
  localparam logic [3:0] BLK_ALL    = 4'b1111;

  // STAT interrupt select bits
  localparam int unsigned SEL_HBLANK = 0;
  localparam int unsigned SEL_VBLANK = 1;
  localparam int unsigned SEL_OAM    = 2;
  localparam int unsigned SEL_LYC    = 3;

endpackage

`default_nettype wire

// ----- sv/lcdstat_if.sv -----
// Valid/ready channel interfaces for the LCD timing block: one dot word in, one status word out.
// No dependencies.
`default_nettype none

interface lcdstat_in_if;
  logic       valid;
  logic       ready;
  logic       lcd_enable;
  logic [7:0] compare_line;
  logic [3:0] stat_select;
  logic       line_drawn;

  modport source (output valid, lcd_enable, compare_line, stat_select, line_drawn,
                  input ready);
  modport sink   (input valid, lcd_enable, compare_line, stat_select, line_drawn,
                  output ready);
endinterface

interface lcdstat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic [7:0] line;
  logic       coincidence;
  logic       stat_irq;
  logic       vblank_irq;
  logic       oam_rd_lock;
  logic       oam_wr_lock;
  logic       vram_rd_lock;
  logic       vram_wr_lock;

  modport source (output valid, lcd_mode, line, coincidence, stat_irq, vblank_irq,
                  oam_rd_lock, oam_wr_lock, vram_rd_lock, vram_wr_lock,
                  input ready);
  modport sink   (input valid, lcd_mode, line, coincidence, stat_irq, vblank_irq,
                  oam_rd_lock, oam_wr_lock, vram_rd_lock, vram_wr_lock,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lcd_line_timing_stat_irq.sv -----
// LCD line timing with STAT and VBlank interrupts. Every accepted input word is one
// display dot; while ready, the block takes one word per clock and the status word
// for that dot appears in the output register on the next cycle. The input is ready
// whenever the output register is empty or is being taken in the same cycle, so with
// a sink that is always ready the rate is one dot per cycle, set by the single state
// update between the input port and the output register. A line is 456 dots (OAM scan
// 80, drawing until line_drawn, then HBlank); the line counter steps at dot 452 and
// lines 144 to 153 are VBlank. The first line after enabling the LCD is shortened.
// Depends on lcdstat_pkg, lcdstat_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lcd_line_timing_stat_irq (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  lcdstat_in_if.sink      in_i,
  lcdstat_out_if.source   out_o
);
  import lcdstat_pkg::*;

  // Timing state
  logic [DotW-1:0]  dot_q, dot_d;
  mode_e            mode_q, mode_d;
  logic [LineW-1:0] line_q, line_d;
  logic             irq_line_q, irq_line_d;
  logic             vbl_pend_q, vbl_pend_d;
  logic             frame_end_q, frame_end_d;
  logic             active_q, active_d;
  logic             coin_q, coin_d;
  logic [3:0]       blk_q, blk_d;

  // Output register
  logic             out_valid_q;
  logic [1:0]       smode_q, smode_d;
  logic             sirq_q, sirq_d;
  logic             virq_q, virq_d;

  logic             accept;
  logic [2:0]       mode_bits;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign mode_bits  = mode_q;

  // Per-dot sequencing
  always_comb begin
    logic c_oam, c_hbl, c_vbl, c_lyc, level;
    dot_d       = dot_q;
    mode_d      = mode_q;
    line_d      = line_q;
    irq_line_d  = irq_line_q;
    vbl_pend_d  = vbl_pend_q;
    frame_end_d = frame_end_q;
    active_d    = active_q;
    coin_d      = coin_q;
    blk_d       = blk_q;
    smode_d     = 2'b00;
    sirq_d      = 1'b0;
    virq_d      = 1'b0;
    c_oam       = 1'b0;
    c_hbl       = 1'b0;
    c_vbl       = 1'b0;
    c_lyc       = 1'b0;
    level       = 1'b0;

    if (!in_i.lcd_enable) begin
      // switch-off clears the counters and drops back to the first-line mode
      if (active_q) begin
        active_d = 1'b0;
        dot_d    = '0;
        line_d   = '0;
        mode_d   = MODE_FIRST;
        blk_d    = BLK_NONE;
      end
    end else if (!active_q) begin
      // switch-on dot: nothing counted yet
      active_d = 1'b1;
    end else begin
      dot_d   = dot_q + 1'b1;
      smode_d = mode_bits[1:0];

      case (mode_q)
        MODE_FIRST: begin
          if (dot_d == DOT_OAM_LATE) begin
            dot_d  = DOT_OAM_END;
            mode_d = MODE_DRAW;
            blk_d  = BLK_ALL;
          end
        end
        MODE_OAM: begin
          if (dot_d == DOT_OAM_LATE) begin
            blk_d[BLK_VRAM_R] = 1'b1;
            blk_d[BLK_OAM_W]  = 1'b0;
          end
          if (dot_d == DOT_OAM_END) begin
            mode_d = MODE_DRAW;
            blk_d  = BLK_ALL;
          end
        end
        MODE_DRAW: begin
          if (in_i.line_drawn) begin
            mode_d = MODE_HBLANK;
            blk_d  = BLK_NONE;
          end
        end
        MODE_HBLANK: begin
          if (dot_d == DOT_LINE_STEP) begin
            line_d           = line_q + 1'b1;
            blk_d[BLK_OAM_R] = 1'b1;
          end
          if (dot_d == DOT_LINE_END) begin
            dot_d = '0;
            if (line_d == LINE_VBLANK) begin
              mode_d     = MODE_VBLANK;
              vbl_pend_d = 1'b1;
              blk_d      = BLK_NONE;
            end else begin
              mode_d = MODE_OAM;
              blk_d  = BLK_OAM;
            end
          end
        end
        MODE_VBLANK: begin
          if (vbl_pend_q) begin
            virq_d     = 1'b1;
            vbl_pend_d = 1'b0;
          end
          // last line snaps back to 0 early in the line
          if (line_q == LINE_LAST && dot_d == DOT_SNAP) begin
            line_d      = '0;
            frame_end_d = 1'b1;
          end
          if (dot_d == DOT_LINE_STEP && !frame_end_d) begin
            line_d = line_d + 1'b1;
          end
          if (dot_d == DOT_LINE_END) begin
            dot_d = '0;
            if (frame_end_d) begin
              frame_end_d = 1'b0;
              mode_d      = MODE_OAM;
              blk_d       = BLK_OAM;
            end
          end
        end
        default: ;
      endcase

      // STAT line and its rising edge
      c_oam = (mode_bits[1:0] == 2'(MODE_OAM)) && in_i.stat_select[SEL_OAM];
      c_hbl = (mode_bits[1:0] == 2'(MODE_HBLANK)) && in_i.stat_select[SEL_HBLANK];
      c_vbl = (mode_bits[1:0] == 2'(MODE_VBLANK)) &&
              (in_i.stat_select[SEL_VBLANK] ||
               (in_i.stat_select[SEL_OAM] && line_d == LINE_VBLANK));
      c_lyc = (line_d == in_i.compare_line) && in_i.stat_select[SEL_LYC];
      level      = c_oam || c_hbl || c_vbl || c_lyc;
      sirq_d     = level && !irq_line_q;
      irq_line_d = level;

      coin_d = (dot_d >= DOT_LINE_STEP) ? 1'b0 : (line_d == in_i.compare_line);
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= '0;
      mode_q      <= MODE_FIRST;
      line_q      <= '0;
      irq_line_q  <= 1'b0;
      vbl_pend_q  <= 1'b0;
      frame_end_q <= 1'b0;
      active_q    <= 1'b0;
      coin_q      <= 1'b0;
      blk_q       <= BLK_NONE;
    end else if (accept) begin
      dot_q       <= dot_d;
      mode_q      <= mode_d;
      line_q      <= line_d;
      irq_line_q  <= irq_line_d;
      vbl_pend_q  <= vbl_pend_d;
      frame_end_q <= frame_end_d;
      active_q    <= active_d;
      coin_q      <= coin_d;
      blk_q       <= blk_d;
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Output word payload; line, flags and blocks come from the updated state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smode_q <= smode_d;
      sirq_q  <= sirq_d;
      virq_q  <= virq_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lcd_mode     = smode_q;
  assign out_o.line         = line_q;
  assign out_o.coincidence  = coin_q;
  assign out_o.stat_irq     = sirq_q;
  assign out_o.vblank_irq   = virq_q;
  assign out_o.oam_rd_lock  = blk_q[BLK_OAM_R];
  assign out_o.oam_wr_lock  = blk_q[BLK_OAM_W];
  assign out_o.vram_rd_lock = blk_q[BLK_VRAM_R];
  assign out_o.vram_wr_lock = blk_q[BLK_VRAM_W];

  // Checks
  `LCDSTAT_ASSERT_IMP(a_vram_wr_blk_all, blk_q[BLK_VRAM_W], blk_q == BLK_ALL)
  `LCDSTAT_ASSERT_IMP(a_coin_before_step, coin_q, dot_q < DOT_LINE_STEP)
  `LCDSTAT_ASSERT_IMP(a_off_counters_clear, !active_q, dot_q == '0 && line_q == '0)
  `LCDSTAT_ASSERT(a_vbl_irq_in_vblank,
                  !(out_valid_q && virq_q) || smode_q == 2'(MODE_VBLANK))

endmodule

`default_nettype wire

// ----- test/lcd_line_timing_stat_irq_test.sv -----
// Self-checking testbench for lcd_line_timing_stat_irq: directed LCD on/off dots, random
// scanlines, endless drawing and a fresh enable, checked against an in-bench dot predictor.
// Depends on lcdstat_pkg, lcdstat_if and the lcd_line_timing_stat_irq RTL.
`timescale 1ns / 1ps

module lcd_line_timing_stat_irq_test;
  import lcdstat_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;

  // One status word as the block emits it
  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       oam_rd;
    logic       oam_wr;
    logic       vram_rd;
    logic       vram_wr;
  } status_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcdstat_in_if  in_if ();
  lcdstat_out_if out_if ();

  lcd_line_timing_stat_irq i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted timing state
  logic [DotW-1:0]  dot_cnt;
  logic [LineW-1:0] line_cnt;
  mode_e            cur_mode;
  logic             stat_level;
  logic             vbl_pending;
  logic             frame_done;
  logic             lcd_on;
  logic             coinc_flag;
  logic [3:0]       blk;

  status_word_t status_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned send_calm;
  int unsigned recv_calm;

  int unsigned n_errors;
  int unsigned n_words;
  int unsigned n_stat_irq;
  int unsigned n_vbl_irq;
  int unsigned top_line;
  int unsigned cycle_cnt;

  function automatic void reset_timing();
    dot_cnt     = '0;
    line_cnt    = '0;
    cur_mode    = MODE_FIRST;
    stat_level  = 1'b0;
    vbl_pending = 1'b0;
    frame_done  = 1'b0;
    lcd_on      = 1'b0;
    coinc_flag  = 1'b0;
    blk         = BLK_NONE;
  endfunction

  // Mode entry sets the access blocks for the new mode
  function automatic void set_mode(input mode_e m);
    cur_mode = m;
    if (m == MODE_VBLANK) vbl_pending = 1'b1;
    if (m == MODE_OAM) begin
      blk = BLK_OAM;
    end else if (m == MODE_DRAW) begin
      blk = BLK_ALL;
    end else begin
      blk = BLK_NONE;
    end
  endfunction

  function automatic status_word_t status_now(input logic [1:0] shown, input logic sirq,
                                              input logic virq);
    status_word_t s;
    s.lcd_mode    = shown;
    s.line        = line_cnt;
    s.coincidence = coinc_flag;
    s.stat_irq    = sirq;
    s.vblank_irq  = virq;
    s.oam_rd      = blk[BLK_OAM_R];
    s.oam_wr      = blk[BLK_OAM_W];
    s.vram_rd     = blk[BLK_VRAM_R];
    s.vram_wr     = blk[BLK_VRAM_W];
    return s;
  endfunction

  // Advance the timing by one dot and return the status word for it
  function automatic status_word_t advance_dot(input logic en, input logic [7:0] cmp,
                                               input logic [3:0] sel, input logic drawn);
    logic [1:0] shown;
    logic       vbl_pulse;
    logic       c_oam;
    logic       c_hbl;
    logic       c_vbl;
    logic       c_lyc;
    logic       level;
    logic       rise;
    vbl_pulse = 1'b0;

    // LCD off or just switched: no dot is counted
    if (!en) begin
      if (lcd_on) begin
        lcd_on   = 1'b0;
        dot_cnt  = '0;
        line_cnt = '0;
        set_mode(MODE_FIRST);
      end
      return status_now(2'd0, 1'b0, 1'b0);
    end
    if (!lcd_on) begin
      lcd_on = 1'b1;
      return status_now(2'd0, 1'b0, 1'b0);
    end

    dot_cnt = dot_cnt + 1'b1;
    shown   = 2'(cur_mode);

    case (cur_mode)
      MODE_FIRST: begin
        // shortened scan on the first line after enable
        if (dot_cnt == DOT_OAM_LATE) begin
          dot_cnt = DOT_OAM_END;
          set_mode(MODE_DRAW);
        end
      end
      MODE_OAM: begin
        if (dot_cnt == DOT_OAM_LATE) begin
          blk[BLK_VRAM_R] = 1'b1;
          blk[BLK_OAM_W]  = 1'b0;
        end
        if (dot_cnt == DOT_OAM_END) set_mode(MODE_DRAW);
      end
      MODE_DRAW: begin
        if (drawn) set_mode(MODE_HBLANK);
      end
      MODE_HBLANK: begin
        if (dot_cnt == DOT_LINE_STEP) begin
          line_cnt       = line_cnt + 1'b1;
          blk[BLK_OAM_R] = 1'b1;
        end
        if (dot_cnt == DOT_LINE_END) begin
          dot_cnt = '0;
          if (line_cnt == LINE_VBLANK) set_mode(MODE_VBLANK);
          else set_mode(MODE_OAM);
        end
      end
      MODE_VBLANK: begin
        if (vbl_pending) begin
          vbl_pulse   = 1'b1;
          vbl_pending = 1'b0;
        end
        // last line snaps back to 0 early
        if (line_cnt == LINE_LAST && dot_cnt == DOT_SNAP) begin
          line_cnt   = '0;
          frame_done = 1'b1;
        end
        if (dot_cnt == DOT_LINE_STEP && !frame_done) line_cnt = line_cnt + 1'b1;
        if (dot_cnt == DOT_LINE_END) begin
          dot_cnt = '0;
          if (frame_done) begin
            frame_done = 1'b0;
            set_mode(MODE_OAM);
          end
        end
      end
      default: ;
    endcase

    // STAT line: pulse on its rising edge
    c_oam = shown == 2'(MODE_OAM) && sel[SEL_OAM];
    c_hbl = shown == 2'(MODE_HBLANK) && sel[SEL_HBLANK];
    c_vbl = shown == 2'(MODE_VBLANK) &&
            (sel[SEL_VBLANK] || (sel[SEL_OAM] && line_cnt == LINE_VBLANK));
    c_lyc = line_cnt == cmp && sel[SEL_LYC];
    level = c_oam || c_hbl || c_vbl || c_lyc;
    rise  = !stat_level && level;
    stat_level = level;

    coinc_flag = (dot_cnt >= DOT_LINE_STEP) ? 1'b0 : (line_cnt == cmp);
    return status_now(shown, rise, vbl_pulse);
  endfunction

  // Send one dot word; the expected status is queued on acceptance
  task automatic send_dot(input logic en, input logic [7:0] cmp, input logic [3:0] sel,
                          input logic drawn);
    int unsigned gap;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 99) < 3) begin
      send_calm = $urandom_range(16, 64);
    end else begin
      while (gap < 8 && $urandom_range(0, 99) < send_idle_pct) gap++;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.lcd_enable   <= en;
    in_if.compare_line <= cmp;
    in_if.stat_select  <= sel;
    in_if.line_drawn   <= drawn;
    do @(posedge clk_i); while (!in_if.ready);
    status_q.insert(status_q.size(), advance_dot(en, cmp, sel, drawn));
  endtask

  // Scanlines with random content; unless drawing is held, it ends at a random dot per line
  task automatic drive_lines(input int unsigned n_dots, input bit may_switch_off,
                             input bit hold_drawing);
    logic [7:0]  cmp;
    logic [3:0]  sel;
    logic        en;
    logic        drawn;
    int unsigned off_left;
    int unsigned draw_at;
    cmp      = 8'($urandom_range(0, 255));
    sel      = 4'($urandom_range(0, 15));
    off_left = 0;
    draw_at  = $urandom_range(81, 380);
    for (int unsigned i = 0; i < n_dots; i++) begin
      // new compare value and draw length at line start, sometimes mid-line
      if (dot_cnt == '0 || $urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 5))
          0: cmp = line_cnt;
          1: cmp = line_cnt + 1'b1;
          2: cmp = 8'($urandom_range(LINE_VBLANK, LINE_LAST));
          3: cmp = 8'd0;
          4: cmp = 8'd255;
          default: cmp = 8'($urandom_range(0, 255));
        endcase
        draw_at = $urandom_range(81, 380);
      end
      if ($urandom_range(0, 49) == 0) sel = 4'($urandom_range(0, 15));
      if (may_switch_off && off_left == 0 && $urandom_range(0, 299) == 0)
        off_left = $urandom_range(1, 3);
      en = (off_left == 0);
      if (off_left > 0) off_left--;
      // held drawing only finishes after the dot counter wrapped
      if (hold_drawing)
        drawn = cur_mode == MODE_DRAW && dot_cnt inside {[9'd20 : 9'd60]};
      else
        drawn = (cur_mode == MODE_DRAW && dot_cnt >= draw_at) || $urandom_range(0, 99) == 0;
      send_dot(en, cmp, sel, drawn);
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // LCD off, switch on, switch off, field extremes, every select bit
  task automatic test_power_switching();
    send_dot(1'b0, 8'd0, 4'h0, 1'b0);
    send_dot(1'b0, 8'd255, 4'hF, 1'b1);
    send_dot(1'b1, 8'd0, 4'hF, 1'b0);
    send_dot(1'b1, 8'd0, 4'(1 << SEL_LYC), 1'b0);
    send_dot(1'b1, 8'd255, 4'h0, 1'b1);
    send_dot(1'b1, 8'd255, 4'(1 << SEL_HBLANK), 1'b0);
    send_dot(1'b1, 8'd1, 4'(1 << SEL_OAM), 1'b0);
    send_dot(1'b1, 8'd0, 4'(1 << SEL_VBLANK), 1'b0);
    send_dot(1'b0, 8'd0, 4'hF, 1'b0);
    send_dot(1'b0, 8'd128, 4'hA, 1'b1);
    send_dot(1'b1, 8'd127, 4'h5, 1'b0);
    send_dot(1'b1, 8'd0, 4'(1 << SEL_LYC), 1'b1);
    send_dot(1'b1, 8'd255, 4'(1 << SEL_LYC), 1'b0);
    send_dot(1'b1, 8'd0, 4'(1 << SEL_LYC), 1'b0);
    send_dot(1'b0, 8'd255, 4'h0, 1'b0);
    send_dot(1'b1, 8'd0, 4'h0, 1'b0);
  endtask

  task automatic test_random_lines(input int unsigned n_dots);
    drive_lines(n_dots, 1'b1, 1'b0);
  endtask

  // Drawing never finishes before the dot counter wraps
  task automatic test_endless_drawing();
    drive_lines(800, 1'b0, 1'b1);
  endtask

  // Fresh enable, then part of the shortened first line
  task automatic test_fresh_enable();
    send_dot(1'b0, 8'd0, 4'h0, 1'b0);
    send_dot(1'b1, 8'd0, 4'h0, 1'b0);
    drive_lines(330, 1'b0, 1'b0);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("Mismatch at word %0d, %s: got %0d, expected %0d", n_words, what, got, want);
    n_errors++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Receiver: random stalls with calm stretches
  always @(negedge clk_i) begin
    if (recv_calm > 0) begin
      recv_calm    <= recv_calm - 1;
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      recv_calm    <= $urandom_range(16, 64);
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted status word with the oldest prediction
  always @(posedge clk_i) begin : check_status
    status_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("word with nothing pending", 1, 0);
      end else begin
        want = status_q.pop_front();
        check_field("lcd_mode", out_if.lcd_mode, want.lcd_mode);
        check_field("line", out_if.line, want.line);
        check_field("coincidence", out_if.coincidence, want.coincidence);
        check_field("stat_irq", out_if.stat_irq, want.stat_irq);
        check_field("vblank_irq", out_if.vblank_irq, want.vblank_irq);
        check_field("oam_rd_lock", out_if.oam_rd_lock, want.oam_rd);
        check_field("oam_wr_lock", out_if.oam_wr_lock, want.oam_wr);
        check_field("vram_rd_lock", out_if.vram_rd_lock, want.vram_rd);
        check_field("vram_wr_lock", out_if.vram_wr_lock, want.vram_wr);
      end
      if (out_if.stat_irq) n_stat_irq++;
      if (out_if.vblank_irq) n_vbl_irq++;
      if (out_if.line > top_line) top_line = out_if.line;
      n_words++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words pending", cycle_cnt, status_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.lcd_enable   = 1'b0;
    in_if.compare_line = 8'd0;
    in_if.stat_select  = 4'h0;
    in_if.line_drawn   = 1'b0;
    out_if.ready       = 1'b0;
    send_calm          = 0;
    recv_calm          = 0;
    n_errors           = 0;
    n_words            = 0;
    n_stat_irq         = 0;
    n_vbl_irq          = 0;
    top_line           = 0;
    cycle_cnt          = 0;
    set_idling(32, 58);
    reset_timing();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_power_switching();
    test_random_lines(400);
    set_idling(58, 32);
    test_endless_drawing();
    test_fresh_enable();
    set_idling(0, 0);
    test_random_lines(200);

    // drain and let any stray word show up
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Checked %0d status words over lines 0 to %0d with the LCD switched on and off,",
             n_words, top_line);
    $display("seeing %0d STAT and %0d VBlank interrupts; %0d mismatches",
             n_stat_irq, n_vbl_irq, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
